// ===== hw/rtl/tes_pkg.sv =====
// ----------------------------------------------------------------------------
// tes_pkg: shared constants for triangle edge setup
// Edge codes, slope format and divider stage sizing.
// ----------------------------------------------------------------------------
package tes_pkg;

  // Edge order within one triangle
  localparam logic [1:0] EDGE_TM = 2'd0;  // top to middle
  localparam logic [1:0] EDGE_TB = 2'd1;  // top to bottom
  localparam logic [1:0] EDGE_MB = 2'd2;  // middle to bottom

  // Slope format: signed Q16.16
  localparam int         SLOPE_FRAC = 16;
  localparam logic [31:0] SLOPE_ONE = 32'h0001_0000;

  // Quotient bits resolved per divider pipeline stage
  localparam int DIV_STEPS = 4;

endpackage

// ===== hw/rtl/tes_div.sv =====
// ----------------------------------------------------------------------------
// tes_div: pipelined unsigned restoring divider
// Resolves tes_pkg::DIV_STEPS quotient bits per stage and carries a side
// payload alongside. All stages advance together on en_i.
// ----------------------------------------------------------------------------
module tes_div #(
  parameter int DVW = 16,
  parameter int NW  = 32,
  parameter int SW  = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DVW-1:0] den_i,
  input  logic [SW-1:0]  side_i,
  output logic           valid_o,
  output logic [NW-1:0]  quo_o,
  output logic [SW-1:0]  side_o
);

  localparam int Bps  = tes_pkg::DIV_STEPS;
  localparam int Nstg = (NW + Bps - 1) / Bps;
  localparam int Np   = Nstg * Bps;

  logic [Nstg-1:0] vld_q;
  logic [DVW-1:0]  rem_q  [Nstg];
  logic [Np-1:0]   nq_q   [Nstg];
  logic [DVW-1:0]  den_q  [Nstg];
  logic [SW-1:0]   side_q [Nstg];

  for (genvar g = 0; g < Nstg; g++) begin : g_stage
    logic           vld_in;
    logic [DVW-1:0] rem_in;
    logic [Np-1:0]  nq_in;
    logic [DVW-1:0] den_in;
    logic [SW-1:0]  side_in;
    logic [DVW-1:0] rem_d;
    logic [Np-1:0]  nq_d;

    if (g == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign nq_in   = Np'(num_i);
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign nq_in   = nq_q[g-1];
      assign den_in  = den_q[g-1];
      assign side_in = side_q[g-1];
    end

    // Bps shift-subtract steps per stage
    always_comb begin
      logic [DVW:0]   t;
      logic [DVW-1:0] r;
      logic [Np-1:0]  n;
      r = rem_in;
      n = nq_in;
      for (int k = 0; k < Bps; k++) begin
        t = {r, n[Np-1]};
        if (t >= {1'b0, den_in}) begin
          t = t - {1'b0, den_in};
          n = {n[Np-2:0], 1'b1};
        end else begin
          n = {n[Np-2:0], 1'b0};
        end
        r = t[DVW-1:0];
      end
      rem_d = r;
      nq_d  = n;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        nq_q[g]   <= nq_d;
        den_q[g]  <= den_in;
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[Nstg-1];
  assign quo_o   = nq_q[Nstg-1][NW-1:0];
  assign side_o  = side_q[Nstg-1];

endmodule

// ===== hw/rtl/triangle_edge_setup_top.sv =====
// ----------------------------------------------------------------------------
// triangle_edge_setup_top: scanline rasterizer edge setup
// Sorts a triangle's vertices by y and emits edges TM, TB and MB with span,
// upper end and saturated Q16.16 negated inverse slope.
// ----------------------------------------------------------------------------
// A triangle request is taken while the previous one issues its last edge: the
// block issues one edge per cycle into its pipeline, three per triangle, while
// the result channel does not stall, so that channel can run full at one result
// per cycle. The issue stage is the limit. The slope divider resolves 4 quotient
// bits per stage. When the result channel stalls, the whole pipeline holds.
module triangle_edge_setup_top #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 4,
  parameter int ID_WIDTH    = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ID_WIDTH-1:0]                 face_index_i,
  input  logic signed [COORD_WIDTH-1:0]       x_a_i,
  input  logic signed [COORD_WIDTH-1:0]       y_a_i,
  input  logic signed [COORD_WIDTH-1:0]       x_b_i,
  input  logic signed [COORD_WIDTH-1:0]       y_b_i,
  input  logic signed [COORD_WIDTH-1:0]       x_c_i,
  input  logic signed [COORD_WIDTH-1:0]       y_c_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ID_WIDTH-1:0]                 polygon_tag_o,
  output logic [1:0]                          edge_number_o,
  output logic signed [COORD_WIDTH-1:0]       upper_x_o,
  output logic signed [COORD_WIDTH-FRAC_BITS+1:0] row_span_o,
  output logic signed [31:0]                  inverse_slope_o,
  output logic signed [COORD_WIDTH-1:0]       upper_y_o,
  output logic                                horizontal_o,
  output logic                                last_edge_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int RW   = COORD_WIDTH - FRAC_BITS + 2;
  localparam int NW   = COORD_WIDTH + tes_pkg::SLOPE_FRAC;
  localparam int EW   = (NW > 32) ? NW + 1 : 33;
  localparam int SW   = ID_WIDTH + 2 + CW + RW + CW + 2;
  localparam logic [EW-1:0] LimPos = {{(EW-31){1'b0}}, {31{1'b1}}};
  localparam logic [EW-1:0] LimNeg = LimPos + EW'(1);

  logic adv;

  // ---------------- triangle hold and edge issue ----------------
  logic                 tri_vld_q;
  logic [1:0]           cnt_q;
  logic [ID_WIDTH-1:0]  id_q;
  logic signed [CW-1:0] xa_q, ya_q, xb_q, yb_q, xc_q, yc_q;

  assign in_ready_o = !tri_vld_q || (adv && (cnt_q == tes_pkg::EDGE_MB));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_vld_q <= 1'b0;
      cnt_q     <= tes_pkg::EDGE_TM;
    end else if (in_valid_i && in_ready_o) begin
      tri_vld_q <= 1'b1;
      cnt_q     <= tes_pkg::EDGE_TM;
    end else if (adv && tri_vld_q) begin
      if (cnt_q == tes_pkg::EDGE_MB) begin
        tri_vld_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      id_q <= face_index_i;
      xa_q <= x_a_i;  ya_q <= y_a_i;
      xb_q <= x_b_i;  yb_q <= y_b_i;
      xc_q <= x_c_i;  yc_q <= y_c_i;
    end
  end

  // rank vertices by y with the strict comparison tree
  logic signed [CW-1:0] tx, ty, mx, my, bx, by;
  logic signed [CW-1:0] ux_c, uy_c, lx_c, ly_c;

  always_comb begin
    if (ya_q < yb_q) begin
      if (yb_q < yc_q) begin
        tx = xc_q; ty = yc_q; mx = xb_q; my = yb_q; bx = xa_q; by = ya_q;
      end else if (ya_q < yc_q) begin
        tx = xb_q; ty = yb_q; mx = xc_q; my = yc_q; bx = xa_q; by = ya_q;
      end else begin
        tx = xb_q; ty = yb_q; mx = xa_q; my = ya_q; bx = xc_q; by = yc_q;
      end
    end else begin
      if (ya_q < yc_q) begin
        tx = xc_q; ty = yc_q; mx = xa_q; my = ya_q; bx = xb_q; by = yb_q;
      end else if (yb_q < yc_q) begin
        tx = xa_q; ty = ya_q; mx = xc_q; my = yc_q; bx = xb_q; by = yb_q;
      end else begin
        tx = xa_q; ty = ya_q; mx = xb_q; my = yb_q; bx = xc_q; by = yc_q;
      end
    end
  end

  // endpoints of the edge being issued
  always_comb begin
    unique case (cnt_q)
      tes_pkg::EDGE_TM: begin
        ux_c = tx; uy_c = ty; lx_c = mx; ly_c = my;
      end
      tes_pkg::EDGE_TB: begin
        ux_c = tx; uy_c = ty; lx_c = bx; ly_c = by;
      end
      default: begin
        ux_c = mx; uy_c = my; lx_c = bx; ly_c = by;
      end
    endcase
  end

  // ---------------- stage 1: edge endpoints ----------------
  logic                 s1_vld_q;
  logic [ID_WIDTH-1:0]  s1_id_q;
  logic [1:0]           s1_num_q;
  logic signed [CW-1:0] s1_ux_q, s1_uy_q, s1_lx_q, s1_ly_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= tri_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_id_q  <= id_q;
      s1_num_q <= cnt_q;
      s1_ux_q  <= ux_c;
      s1_uy_q  <= uy_c;
      s1_lx_q  <= lx_c;
      s1_ly_q  <= ly_c;
    end
  end

  // ---------------- stage 2: differences and row span ----------------
  logic signed [CW:0]   dx_c, den_c, ly_up_c;
  logic signed [RW-1:0] span_c;

  assign dx_c    = (CW+1)'(s1_ux_q) - (CW+1)'(s1_lx_q);
  assign den_c   = (CW+1)'(s1_ly_q) - (CW+1)'(s1_uy_q);
  assign ly_up_c = (CW+1)'(s1_ly_q) + (CW+1)'((1 << FRAC_BITS) - 1);
  assign span_c  = RW'(s1_uy_q >>> FRAC_BITS) - RW'(ly_up_c >>> FRAC_BITS);

  logic                 s2_vld_q;
  logic [ID_WIDTH-1:0]  s2_id_q;
  logic [1:0]           s2_num_q;
  logic signed [CW-1:0] s2_upx_q, s2_upy_q;
  logic signed [CW:0]   s2_dx_q, s2_den_q;
  logic signed [RW-1:0] s2_span_q;
  logic                 s2_flat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  // upper end is the first of the pair only when strictly above
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_id_q   <= s1_id_q;
      s2_num_q  <= s1_num_q;
      s2_upx_q  <= (s1_uy_q > s1_ly_q) ? s1_ux_q : s1_lx_q;
      s2_upy_q  <= (s1_uy_q > s1_ly_q) ? s1_uy_q : s1_ly_q;
      s2_dx_q   <= dx_c;
      s2_den_q  <= den_c;
      s2_span_q <= span_c;
      s2_flat_q <= (s1_uy_q == s1_ly_q);
    end
  end

  // ---------------- stage 3: magnitudes and sign ----------------
  logic                 s3_vld_q;
  logic [NW-1:0]        s3_num_q;
  logic [CW-1:0]        s3_den_q;
  logic [SW-1:0]        s3_side_q;
  logic [CW:0]          dx_abs_c, den_abs_c;

  assign dx_abs_c  = s2_dx_q[CW]  ? -s2_dx_q  : s2_dx_q;
  assign den_abs_c = s2_den_q[CW] ? -s2_den_q : s2_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_num_q  <= {dx_abs_c[CW-1:0], {tes_pkg::SLOPE_FRAC{1'b0}}};
      s3_den_q  <= den_abs_c[CW-1:0];
      s3_side_q <= {s2_id_q, s2_num_q, s2_upx_q, s2_span_q, s2_upy_q, s2_flat_q,
                    s2_dx_q[CW] ^ s2_den_q[CW]};
    end
  end

  // ---------------- divider stages ----------------
  logic          dv_vld;
  logic [NW-1:0] dv_quo;
  logic [SW-1:0] dv_side;

  tes_div #(
    .DVW (CW),
    .NW  (NW),
    .SW  (SW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s3_vld_q),
    .num_i   (s3_num_q),
    .den_i   (s3_den_q),
    .side_i  (s3_side_q),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // ---------------- output register: sign and saturation ----------------
  logic [ID_WIDTH-1:0]  d_id;
  logic [1:0]           d_num;
  logic signed [CW-1:0] d_upx, d_upy;
  logic signed [RW-1:0] d_span;
  logic                 d_flat, d_neg;
  logic [EW-1:0]        q_ext;
  logic [31:0]          slope_c;

  assign {d_id, d_num, d_upx, d_span, d_upy, d_flat, d_neg} = dv_side;
  assign q_ext = EW'(dv_quo);

  always_comb begin
    if (d_flat) begin
      slope_c = tes_pkg::SLOPE_ONE;
    end else if (d_neg) begin
      slope_c = (q_ext > LimNeg) ? 32'h8000_0000 : (32'd0 - q_ext[31:0]);
    end else begin
      slope_c = (q_ext > LimPos) ? 32'h7FFF_FFFF : q_ext[31:0];
    end
  end

  logic out_vld_q;

  assign adv = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      polygon_tag_o   <= d_id;
      edge_number_o   <= d_num;
      upper_x_o       <= d_upx;
      row_span_o      <= d_span;
      inverse_slope_o <= slope_c;
      upper_y_o       <= d_upy;
      horizontal_o    <= d_flat;
      last_edge_o     <= (d_num == tes_pkg::EDGE_MB);
    end
  end

  assign out_valid_o = out_vld_q;

  // ---------------- assertions ----------------
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tri_vld_q && (cnt_q != tes_pkg::EDGE_MB)) |-> !in_ready_o)
    else $error("new triangle taken before all edges issued");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (tri_vld_q && (cnt_q == tes_pkg::EDGE_TM)))
    else $error("accepted triangle does not start at first edge");

  a_last_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (last_edge_o == (edge_number_o == tes_pkg::EDGE_MB)))
    else $error("last edge flag disagrees with edge number");

  a_flat_slope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && horizontal_o) |-> (inverse_slope_o == tes_pkg::SLOPE_ONE))
    else $error("horizontal edge without unit slope");

endmodule
